>>> src/vfv_pkg.sv
// Shared types, voxel codes and the id classification for the voxel face visibility block.
`default_nettype none

package vfv_pkg;

  localparam int SIDE_DEFAULT = 16;
  localparam int CODE_W = 3;

  localparam logic [CODE_W-1:0] CODE_EMPTY = 3'd0;
  localparam logic [CODE_W-1:0] CODE_GRASS = 3'd1;
  localparam logic [CODE_W-1:0] CODE_SAND  = 3'd2;
  localparam logic [CODE_W-1:0] CODE_WATER = 3'd3;
  localparam logic [CODE_W-1:0] CODE_OTHER = 3'd4;

  localparam logic [15:0] ID_EMPTY = 16'd0;
  localparam logic [15:0] ID_GRASS = 16'd1;
  localparam logic [15:0] ID_SAND  = 16'd2;
  localparam logic [15:0] ID_WATER = 16'd3;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] COLOUR_OTHER = 2'd3;

  typedef struct packed {
    logic        mode;
    logic [5:0]  coord_x;
    logic [5:0]  coord_y;
    logic [5:0]  coord_z;
    logic [15:0] block_id;
  } in_t;

  typedef struct packed {
    logic       solid;
    logic [5:0] face_mask;
    logic [1:0] colour_class;
  } out_t;

  function automatic logic [CODE_W-1:0] code_of_id(input logic [15:0] id);
    logic [CODE_W-1:0] code;
    case (id)
      ID_EMPTY: code = CODE_EMPTY;
      ID_GRASS: code = CODE_GRASS;
      ID_SAND:  code = CODE_SAND;
      ID_WATER: code = CODE_WATER;
      default:  code = CODE_OTHER;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

>>> src/voxel_face_visibility.sv
// Top level of the voxel face visibility block: sequencer and voxel memory.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_ready  in_data  (vfv_pkg::in_t)
//   out      output     out_valid/out_ready  out_data (vfv_pkg::out_t)
//
// A query beat steps through seven reads of the single-port voxel memory, one per
// cycle, each through its registered read, and then reaches the output register.
// A write beat passes through the write state; a query outside the chunk goes straight
// to the output register. in_ready returns in the same cycle as the result appears.
// After reset a clearing pass writes every entry empty, with in_ready low throughout.
// A result waits in the output register; the next beat is accepted meanwhile and
// only its final hand-off stalls while out_ready is low.
`default_nettype none

module voxel_face_visibility #(
  parameter int SIDE = vfv_pkg::SIDE_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire vfv_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output vfv_pkg::out_t      out_data
);

  localparam int DEPTH = SIDE ** 3;
  localparam int AW = $clog2(DEPTH);

  logic                       mem_we;
  logic [AW-1:0]              mem_addr;
  logic [vfv_pkg::CODE_W-1:0] mem_wdata;
  logic [vfv_pkg::CODE_W-1:0] mem_rdata;

  vfv_seq #(
    .SIDE  (SIDE),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  vfv_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

>>> src/vfv_store.sv
// Single-port voxel code memory with a registered read.
`default_nettype none

module vfv_store #(
  parameter int DEPTH = vfv_pkg::SIDE_DEFAULT ** 3,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             addr,
  input  wire logic [vfv_pkg::CODE_W-1:0] wdata,
  output logic      [vfv_pkg::CODE_W-1:0] rdata
);

  logic [vfv_pkg::CODE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> src/vfv_seq.sv
// Sequencer: clearing pass, writes, seven-read queries and the output register.
`default_nettype none

module vfv_seq #(
  parameter int SIDE  = vfv_pkg::SIDE_DEFAULT,
  parameter int DEPTH = SIDE ** 3,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire vfv_pkg::in_t               in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output vfv_pkg::out_t                   out_data,
  output logic                            mem_we,
  output logic      [AW-1:0]              mem_addr,
  output logic      [vfv_pkg::CODE_W-1:0] mem_wdata,
  input  wire logic [vfv_pkg::CODE_W-1:0] mem_rdata
);

  localparam int SQ = SIDE * SIDE;
  localparam logic [6:0] SIDE_C = 7'(SIDE);
  localparam logic [5:0] LAST = 6'(SIDE - 1);
  localparam logic [AW-1:0] CLR_END = AW'(DEPTH - 1);
  localparam logic [2:0] STEP_CENTER = 3'd0;
  localparam logic [2:0] STEP_ZM = 3'd1;
  localparam logic [2:0] STEP_ZP = 3'd2;
  localparam logic [2:0] STEP_XM = 3'd3;
  localparam logic [2:0] STEP_XP = 3'd4;
  localparam logic [2:0] STEP_YM = 3'd5;
  localparam logic [2:0] STEP_YP = 3'd6;
  localparam logic [2:0] STEP_LAST = 3'd7;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WRITE,
    S_QUERY,
    S_DONE
  } state_t;

  state_t                     state;
  vfv_pkg::in_t               item;
  logic                       in_range;
  logic [AW-1:0]              clr_addr;
  logic [2:0]                 step;
  logic                       bnd_q;
  logic [vfv_pkg::CODE_W-1:0] code;
  logic [5:0]                 mask;
  logic [5:0]                 nx, ny, nz;
  logic                       bnd;
  logic [AW-1:0]              item_addr;
  vfv_pkg::out_t              res;
  logic                       in_data_range;

  assign in_ready = (state == S_IDLE);
  assign in_data_range = ({1'b0, in_data.coord_x} < SIDE_C) &&
                         ({1'b0, in_data.coord_y} < SIDE_C) &&
                         ({1'b0, in_data.coord_z} < SIDE_C);

  always_comb begin
    nx = item.coord_x;
    ny = item.coord_y;
    nz = item.coord_z;
    bnd = 1'b0;
    unique case (step)
      STEP_ZM: begin
        bnd = (item.coord_z == 6'd0);
        if (!bnd) nz = item.coord_z - 6'd1;
      end
      STEP_ZP: begin
        bnd = (item.coord_z == LAST);
        if (!bnd) nz = item.coord_z + 6'd1;
      end
      STEP_XM: begin
        bnd = (item.coord_x == 6'd0);
        if (!bnd) nx = item.coord_x - 6'd1;
      end
      STEP_XP: begin
        bnd = (item.coord_x == LAST);
        if (!bnd) nx = item.coord_x + 6'd1;
      end
      STEP_YM: begin
        bnd = (item.coord_y == 6'd0);
        if (!bnd) ny = item.coord_y - 6'd1;
      end
      STEP_YP: begin
        bnd = (item.coord_y == LAST);
        if (!bnd) ny = item.coord_y + 6'd1;
      end
      STEP_CENTER, STEP_LAST: begin
      end
      default: begin
      end
    endcase
  end

  assign item_addr = AW'(AW'(nx) * AW'(SQ) + AW'(ny) * AW'(SIDE) + AW'(nz));

  always_comb begin
    mem_we = 1'b0;
    mem_addr = item_addr;
    mem_wdata = vfv_pkg::code_of_id(item.block_id);
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_addr = clr_addr;
      mem_wdata = vfv_pkg::CODE_EMPTY;
    end else if (state == S_WRITE) begin
      mem_we = in_range;
    end
  end

  always_comb begin
    res.solid = (code != vfv_pkg::CODE_EMPTY);
    res.face_mask = res.solid ? mask : 6'd0;
    if (!res.solid) begin
      res.colour_class = 2'd0;
    end else if (code == vfv_pkg::CODE_OTHER) begin
      res.colour_class = vfv_pkg::COLOUR_OTHER;
    end else begin
      res.colour_class = 2'(code - vfv_pkg::CODE_GRASS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      out_valid <= 1'b0;
      step <= STEP_CENTER;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      bnd_q <= bnd;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == CLR_END) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            in_range <= in_data_range;
            code <= vfv_pkg::CODE_EMPTY;
            mask <= '0;
            step <= STEP_CENTER;
            if (in_data.mode == vfv_pkg::MODE_WRITE) begin
              state <= S_WRITE;
            end else if (in_data_range) begin
              state <= S_QUERY;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_WRITE: begin
          state <= S_DONE;
        end
        S_QUERY: begin
          step <= step + 3'd1;
          if (step == STEP_ZM) begin
            code <= mem_rdata;
          end else if (step != STEP_CENTER) begin
            mask[3'(step - 3'd2)] <= bnd_q || (mem_rdata == vfv_pkg::CODE_EMPTY);
          end
          if (step == STEP_LAST) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data <= res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/vfv_checker.sv
// Port-level checker for the voxel face visibility block and its bind.
`default_nettype none

module vfv_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire vfv_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire vfv_pkg::out_t out_data
);

  a_clear_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input ready right after reset, before the clearing pass");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready again in the cycle after a beat was accepted");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled output beat changed or dropped");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.solid) |->
    (out_data.face_mask == 6'd0 && out_data.colour_class == 2'd0))
    else $error("non-solid result carries a face mask or colour class");

endmodule

bind voxel_face_visibility vfv_checker u_vfv_checker (.*);

`default_nettype wire
